[hw/rtl/mrsf_pkg.sv]
// Shared types and constants for the Modbus RTU receive framer.
// No dependencies; imported by the front, queue and back modules.
package mrsf_pkg;

	localparam int IDX_W = 6;                      // byte_index field width
	localparam int TICKS_W = 16;                   // silence counter width
	localparam logic [TICKS_W-1:0] SILENCE_RESET = 16'd3645;  // 35000000 / 9600

	localparam logic [1:0] MODE_STARTUP = 2'd0;
	localparam logic [1:0] MODE_IDLE    = 2'd1;
	localparam logic [1:0] MODE_RECV    = 2'd2;
	localparam logic [1:0] MODE_ERROR   = 2'd3;

	// One completed frame waiting for emission: buffer bank and last index.
	typedef struct packed {
		logic             bank;
		logic [IDX_W-1:0] last;
	} desc_t;

endpackage

[hw/rtl/modbus_rtu_silence_rx_framer_core.sv]
// Modbus RTU receive framer top level: front, request queue, back, buffer.
// Depends on mrsf_pkg, mrsf_ram, mrsf_front, mrsf_desc_q and mrsf_back.
//
// Usage:
//  - Input channel (in_valid/in_ready, kind, rx_byte): kind 0 carries one
//    received byte, kind 1 one timer tick. Every byte restarts the one-shot
//    silence timer; after silence_ticks ticks without a byte the frame ends.
//  - Output channel (out_valid/out_ready): one request per frame byte with
//    data_byte, byte_index and is_last on the final byte. Overlong frames
//    (more than BUF_DEPTH bytes) are dropped and never appear here.
//  - cfg_wr_en/cfg_wr_data write silence_ticks; write it only while idle.
//  - Intake takes one item per cycle while in_ready is high. The frame
//    buffer has two banks, so a new frame can be collected while the
//    previous one is still emitted. in_ready drops only while two
//    finished frames wait (both banks owned by the back part), e.g. when
//    the receiver stalls the output.
//  - After the tick that ends a frame, its bytes are read one at a time
//    (one buffer read port, registered read, one read in flight at a time).
//  - Reset: startup mode, timer armed with 3645 ticks, queue empty. No
//    clearing pass; only bytes written in the current frame are read.
module modbus_rtu_silence_rx_framer_core #(
	parameter int BUF_DEPTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [mrsf_pkg::TICKS_W-1:0] cfg_wr_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         kind,
	input  logic [7:0]                   rx_byte,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [7:0]                   data_byte,
	output logic [mrsf_pkg::IDX_W-1:0]   byte_index,
	output logic                         is_last
);
	import mrsf_pkg::*;

	localparam int IW = $clog2(BUF_DEPTH);
	// Two banks, each padded to a power of two so {bank, index} addresses it.
	localparam int RAM_DEPTH = 2 * (1 << IW);

	logic          wr_en;
	logic [IW:0]   wr_addr;
	logic [7:0]    wr_data;
	logic          rd_en;
	logic [IW:0]   rd_addr;
	logic [7:0]    rd_data;
	logic          push;
	desc_t         push_desc;
	logic          q_full;
	logic          pop;
	logic          q_nonempty;
	desc_t         head;

	mrsf_front #(.BUF_DEPTH(BUF_DEPTH)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.rx_byte     (rx_byte),
		.buf_wr_en   (wr_en),
		.buf_wr_addr (wr_addr),
		.buf_wr_data (wr_data),
		.push        (push),
		.push_desc   (push_desc),
		.q_full      (q_full)
	);

	// Finished frames wait here; an entry is retired on its last byte.
	mrsf_desc_q u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.full      (q_full),
		.pop       (pop),
		.nonempty  (q_nonempty),
		.head      (head)
	);

	mrsf_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_buf (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	mrsf_back #(.BUF_DEPTH(BUF_DEPTH)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_nonempty  (q_nonempty),
		.head        (head),
		.pop         (pop),
		.buf_rd_en   (rd_en),
		.buf_rd_addr (rd_addr),
		.buf_rd_data (rd_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.data_byte   (data_byte),
		.byte_index  (byte_index),
		.is_last     (is_last)
	);

	// Front writes its own bank; the back only reads banks of queued frames.
	a_bank_split: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && rd_en) |-> (wr_addr[IW] != rd_addr[IW]))
		else $error("buffer write and read hit the same bank");

endmodule

[hw/rtl/mrsf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mrsf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[hw/rtl/mrsf_front.sv]
// Front part: accepts bytes and ticks, runs the mode machine and silence
// timer, writes frame bytes to the buffer. Depends on mrsf_pkg.
module mrsf_front #(
	parameter int BUF_DEPTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [mrsf_pkg::TICKS_W-1:0] cfg_wr_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         kind,
	input  logic [7:0]                   rx_byte,
	output logic                         buf_wr_en,
	output logic [$clog2(BUF_DEPTH):0]   buf_wr_addr,
	output logic [7:0]                   buf_wr_data,
	output logic                         push,
	output mrsf_pkg::desc_t              push_desc,
	input  logic                         q_full
);
	import mrsf_pkg::*;

	localparam int IW = $clog2(BUF_DEPTH);

	logic [TICKS_W-1:0] ticks_q;
	logic [TICKS_W-1:0] count_q;
	logic               armed_q;
	logic [1:0]         mode_q;
	logic [IW-1:0]      widx_q;
	logic               bank_q;

	logic               take_byte;
	logic               take_tick;
	logic [IW:0]        next_idx;
	logic               fits;
	logic               expire;

	assign in_ready  = !q_full;
	assign take_byte = in_valid && in_ready && !kind;
	assign take_tick = in_valid && in_ready && kind;
	assign next_idx  = {1'b0, widx_q} + {{IW{1'b0}}, 1'b1};
	assign fits      = next_idx < (IW+1)'(BUF_DEPTH);
	assign expire    = take_tick && armed_q && (count_q <= TICKS_W'(1));

	always_comb begin
		buf_wr_en   = 1'b0;
		buf_wr_addr = {bank_q, widx_q};
		buf_wr_data = rx_byte;
		if (take_byte) begin
			if (mode_q == MODE_IDLE) begin
				buf_wr_en   = 1'b1;
				buf_wr_addr = {bank_q, {IW{1'b0}}};
			end else if (mode_q == MODE_RECV && fits) begin
				buf_wr_en   = 1'b1;
				buf_wr_addr = {bank_q, next_idx[IW-1:0]};
			end
		end
	end

	assign push           = expire && (mode_q == MODE_RECV);
	assign push_desc.bank = bank_q;
	assign push_desc.last = IDX_W'(widx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= SILENCE_RESET;
			count_q <= SILENCE_RESET;
			armed_q <= 1'b1;
			mode_q  <= MODE_STARTUP;
			widx_q  <= '0;
			bank_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				ticks_q <= cfg_wr_data;
			end
			if (take_byte) begin
				count_q <= ticks_q;
				armed_q <= 1'b1;
				unique case (mode_q)
					MODE_IDLE: begin
						widx_q <= '0;
						mode_q <= MODE_RECV;
					end
					MODE_RECV: begin
						if (fits) begin
							widx_q <= next_idx[IW-1:0];
						end else begin
							mode_q <= MODE_ERROR;
						end
					end
					default: ;
				endcase
			end else if (take_tick && armed_q) begin
				if (expire) begin
					count_q <= '0;
					armed_q <= 1'b0;
					mode_q  <= MODE_IDLE;
					if (mode_q == MODE_RECV) begin
						bank_q <= !bank_q;
					end
				end else begin
					count_q <= count_q - TICKS_W'(1);
				end
			end
		end
	end

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("frame pushed into full queue");

	a_bank_flip: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (bank_q != $past(bank_q)) && (mode_q == MODE_IDLE))
		else $error("bank or mode not updated after frame end");

endmodule

[hw/rtl/mrsf_desc_q.sv]
// Two-entry queue of completed-frame requests between front and back.
// An entry is held until its frame is fully emitted. Depends on mrsf_pkg.
module mrsf_desc_q (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mrsf_pkg::desc_t push_desc,
	output logic            full,
	input  logic            pop,
	output logic            nonempty,
	output mrsf_pkg::desc_t head
);
	import mrsf_pkg::*;

	desc_t      ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full     = count_q == 2'd2;
	assign nonempty = count_q != 2'd0;
	assign head     = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != 2'd3) && !(pop && !nonempty))
		else $error("request queue over- or underflow");

endmodule

[hw/rtl/mrsf_back.sv]
// Back part: walks the head frame of the queue through the buffer and
// emits it byte by byte through an output register. Depends on mrsf_pkg.
module mrsf_back #(
	parameter int BUF_DEPTH = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_nonempty,
	input  mrsf_pkg::desc_t            head,
	output logic                       pop,
	output logic                       buf_rd_en,
	output logic [$clog2(BUF_DEPTH):0] buf_rd_addr,
	input  logic [7:0]                 buf_rd_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [7:0]                 data_byte,
	output logic [mrsf_pkg::IDX_W-1:0] byte_index,
	output logic                       is_last
);
	import mrsf_pkg::*;

	localparam int IW = $clog2(BUF_DEPTH);

	logic [IW-1:0] idx_q;
	logic          all_issued_q;
	logic          pend_s1;
	logic [IW-1:0] idx_s1;
	logic          last_s1;
	logic          out_valid_q;
	logic [IW-1:0] out_idx_q;
	logic          out_last_q;
	logic [7:0]    out_data_q;
	logic          issue;
	logic          issue_last;

	assign issue       = q_nonempty && !all_issued_q && !pend_s1
	                     && (!out_valid_q || out_ready);
	assign issue_last  = idx_q == head.last[IW-1:0];
	assign buf_rd_en   = issue;
	assign buf_rd_addr = {head.bank, idx_q};
	assign pop         = out_valid_q && out_ready && out_last_q;

	assign out_valid  = out_valid_q;
	assign data_byte  = out_data_q;
	assign byte_index = IDX_W'(out_idx_q);
	assign is_last    = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			all_issued_q <= 1'b0;
			pend_s1      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			pend_s1 <= issue;
			if (issue) begin
				if (issue_last) begin
					idx_q        <= '0;
					all_issued_q <= 1'b1;
				end else begin
					idx_q <= idx_q + IW'(1);
				end
			end else if (pop) begin
				all_issued_q <= 1'b0;
			end
			if (pend_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			idx_s1  <= idx_q;
			last_s1 <= issue_last;
		end
		if (pend_s1) begin
			out_data_q <= buf_rd_data;
			out_idx_q  <= idx_s1;
			out_last_q <= last_s1;
		end
	end

	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> !out_valid_q)
		else $error("read data arrives while output register is occupied");

	a_pop_done: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> all_issued_q && !pend_s1)
		else $error("frame retired before all bytes were read");

endmodule
